>>> design/assert_macros.svh
// Assertion macros for the quaternion ALU modules; qalu_final uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> design/qalu_pkg.sv
// Types, constants and helper functions of the quaternion ALU.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * WORD_BITS;
    localparam int SQ_W       = PROD_W - 1;
    localparam int HAM_W      = PROD_W + 2;
    localparam int N2_W       = PROD_W + 1;
    localparam int DEN_W      = N2_W;
    localparam int NUM_W      = HAM_W + FRAC_BITS;
    localparam int QUO_W      = WORD_BITS;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQ_IN_W    = 2 * ((N2_W + 1) / 2);
    localparam int ROOT_W     = SQ_IN_W / 2;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int PIPE_STEPS = (ROOT_W > DIV_STEPS) ? ROOT_W : DIV_STEPS;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_DIV       = 4'd3,
        OP_CONJ      = 4'd4,
        OP_NEG       = 4'd5,
        OP_NORM2     = 4'd6,
        OP_NORM      = 4'd7,
        OP_ADDREAL   = 4'd8,
        OP_SUBREAL   = 4'd9,
        OP_SCALE     = 4'd10,
        OP_DIVSCALAR = 4'd11,
        OP_EQUAL     = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        K_DIRECT = 2'd0,
        K_DIV    = 2'd1,
        K_SQRT   = 2'd2
    } kind_t;

    typedef struct packed {
        op_t         op;
        word_t [3:0] a;
        word_t [3:0] b;
    } in_item_t;

    typedef struct packed {
        word_t [3:0] res;
        logic        eq;
        logic        dz;
        logic        ov;
    } result_t;

    typedef struct packed {
        op_t                        op;
        word_t [3:0]                a;
        word_t [3:0]                b;
        logic [3:0][3:0][PROD_W-1:0] p;
        logic [3:0][SQ_W-1:0]       sqa;
        logic [3:0][SQ_W-1:0]       sqb;
    } prod_t;

    typedef struct packed {
        kind_t                   kind;
        result_t                 direct;
        logic [3:0]              neg;
        logic [3:0]              big;
        logic [3:0][QUO_W-1:0]   nlo;
        logic [3:0][DEN_W-1:0]   rem;
        logic [3:0][QUO_W-1:0]   quo;
        logic [DEN_W-1:0]        den;
        logic [SQ_IN_W-1:0]      rad;
        logic [ROOT_W-1:0]       root;
        logic [SQ_REM_W-1:0]     srem;
    } ds_t;

    typedef struct packed {
        logic  ov;
        word_t val;
    } sat_t;

    function automatic logic signed [PROD_W-1:0] smul(input word_t x, input word_t y);
        return PROD_W'(x) * PROD_W'(y);
    endfunction

    // clamp a wide signed value to the word range
    function automatic sat_t sat_wide(input logic signed [NUM_W-1:0] v);
        sat_t r;
        r.ov  = !((&v[NUM_W-1:WORD_BITS-1]) || !(|v[NUM_W-1:WORD_BITS-1]));
        r.val = r.ov ? (v[NUM_W-1] ? WORD_MIN : WORD_MAX) : v[WORD_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/qalu_mult.sv
// Product stage: all cross products of a and b and the squares of both.
`timescale 1ns / 1ps
`default_nettype none

module qalu_mult import qalu_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output prod_t         out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.op = in_data.op;
        data_next.a  = in_data.a;
        data_next.b  = in_data.b;
        for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 4; y++) begin
                data_next.p[x][y] = smul(in_data.a[x], in_data.b[y]);
            end
            data_next.sqa[x] = SQ_W'(smul(in_data.a[x], in_data.a[x]));
            data_next.sqb[x] = SQ_W'(smul(in_data.b[x], in_data.b[x]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/qalu_combine.sv
// Sum stages: Hamilton sums, norms, simple results and divider and root operand setup.
`timescale 1ns / 1ps
`default_nettype none

module qalu_combine import qalu_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire prod_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output ds_t        out_data
);

    typedef struct packed {
        op_t                   op;
        word_t [3:0]           a;
        word_t                 br;
        logic [3:0][HAM_W-1:0] ham;
        logic [N2_W-1:0]       n2a;
        logic [N2_W-1:0]       n2b;
        result_t               direct;
    } mid_t;

    logic mid_valid_reg;
    mid_t mid_reg;
    mid_t mid_next;
    logic out_valid_reg;
    ds_t  out_reg;
    ds_t  out_next;
    logic mid_ready;

    logic signed [HAM_W-1:0] pe [4][4];
    sat_t                    sl_a [4];
    sat_t                    sl_b [4];
    logic signed [HAM_W-1:0] hs [4];
    logic [HAM_W-1:0]        hmag [4];
    logic [WORD_BITS-1:0]    amag [4];
    logic [WORD_BITS-1:0]    bmag;
    logic [NUM_W-1:0]        num [4];
    logic                    is_div;

    assign mid_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mid_valid_reg || mid_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // first stage: signed sums of products and the simple operations
    always_comb begin
        is_div      = (in_data.op == OP_DIV);
        mid_next    = '0;
        mid_next.op = in_data.op;
        mid_next.a  = in_data.a;
        mid_next.br = in_data.b[0];
        for (int x = 0; x < 4; x++) begin
            for (int y = 0; y < 4; y++) begin
                pe[x][y] = (is_div && y != 0) ? -HAM_W'($signed(in_data.p[x][y]))
                                              : HAM_W'($signed(in_data.p[x][y]));
            end
        end
        mid_next.ham[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
        mid_next.ham[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
        mid_next.ham[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
        mid_next.ham[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
        mid_next.n2a = N2_W'(in_data.sqa[0]) + N2_W'(in_data.sqa[1])
                     + N2_W'(in_data.sqa[2]) + N2_W'(in_data.sqa[3]);
        mid_next.n2b = N2_W'(in_data.sqb[0]) + N2_W'(in_data.sqb[1])
                     + N2_W'(in_data.sqb[2]) + N2_W'(in_data.sqb[3]);

        for (int t = 0; t < 4; t++) begin
            sl_a[t] = '0;
        end
        unique case (in_data.op) inside
            OP_ADD: begin
                for (int t = 0; t < 4; t++) begin
                    sl_a[t] = sat_wide(NUM_W'($signed(in_data.a[t]))
                                       + NUM_W'($signed(in_data.b[t])));
                end
            end
            OP_SUB: begin
                for (int t = 0; t < 4; t++) begin
                    sl_a[t] = sat_wide(NUM_W'($signed(in_data.a[t]))
                                       - NUM_W'($signed(in_data.b[t])));
                end
            end
            OP_CONJ, OP_NEG: begin
                for (int t = 0; t < 4; t++) begin
                    sl_a[t] = (in_data.op == OP_CONJ && t == 0)
                            ? sat_wide(NUM_W'($signed(in_data.a[t])))
                            : sat_wide(-NUM_W'($signed(in_data.a[t])));
                end
            end
            OP_ADDREAL, OP_SUBREAL: begin
                sl_a[0] = (in_data.op == OP_ADDREAL)
                        ? sat_wide(NUM_W'($signed(in_data.a[0])) + NUM_W'($signed(in_data.b[0])))
                        : sat_wide(NUM_W'($signed(in_data.a[0])) - NUM_W'($signed(in_data.b[0])));
                for (int t = 1; t < 4; t++) begin
                    sl_a[t] = sat_wide(NUM_W'($signed(in_data.a[t])));
                end
            end
            OP_SCALE: begin
                for (int t = 0; t < 4; t++) begin
                    sl_a[t] = sat_wide(NUM_W'($signed(in_data.p[t][0]) >>> FRAC_BITS));
                end
            end
            OP_EQUAL: begin
                mid_next.direct.eq = (in_data.a == in_data.b);
            end
            default: begin
            end
        endcase
        for (int t = 0; t < 4; t++) begin
            mid_next.direct.res[t] = sl_a[t].val;
        end
        mid_next.direct.ov = sl_a[0].ov | sl_a[1].ov | sl_a[2].ov | sl_a[3].ov;
    end

    // second stage: product scaling and saturation, norm2, divider and root operand setup
    always_comb begin
        out_next        = '0;
        out_next.kind   = K_DIRECT;
        out_next.direct = mid_reg.direct;
        bmag = mid_reg.br[WORD_BITS-1] ? WORD_BITS'(-mid_reg.br) : WORD_BITS'(mid_reg.br);
        for (int t = 0; t < 4; t++) begin
            sl_b[t] = '0;
            hs[t]   = $signed(mid_reg.ham[t]);
            hmag[t] = hs[t][HAM_W-1] ? HAM_W'(-hs[t]) : HAM_W'(hs[t]);
            amag[t] = mid_reg.a[t][WORD_BITS-1] ? WORD_BITS'(-mid_reg.a[t])
                                                : WORD_BITS'(mid_reg.a[t]);
            num[t]  = (mid_reg.op == OP_DIV) ? {hmag[t], FRAC_BITS'(0)}
                                             : NUM_W'({amag[t], FRAC_BITS'(0)});
        end
        unique case (mid_reg.op) inside
            OP_MUL: begin
                for (int t = 0; t < 4; t++) begin
                    sl_b[t] = sat_wide(NUM_W'(hs[t] >>> FRAC_BITS));
                    out_next.direct.res[t] = sl_b[t].val;
                end
                out_next.direct.ov = sl_b[0].ov | sl_b[1].ov | sl_b[2].ov | sl_b[3].ov;
            end
            OP_NORM2: begin
                sl_b[0] = sat_wide(NUM_W'(mid_reg.n2a >> FRAC_BITS));
                out_next.direct.res[0] = sl_b[0].val;
                out_next.direct.ov     = sl_b[0].ov;
            end
            OP_NORM: begin
                out_next.kind = K_SQRT;
                out_next.rad  = SQ_IN_W'(mid_reg.n2a);
            end
            OP_DIV, OP_DIVSCALAR: begin
                out_next.den = (mid_reg.op == OP_DIV) ? mid_reg.n2b : DEN_W'(bmag);
                if (out_next.den == '0) begin
                    out_next.direct.dz = 1'b1;
                end else begin
                    out_next.kind = K_DIV;
                end
                for (int t = 0; t < 4; t++) begin
                    out_next.neg[t] = (mid_reg.op == OP_DIV)
                                    ? hs[t][HAM_W-1]
                                    : (mid_reg.a[t][WORD_BITS-1] ^ mid_reg.br[WORD_BITS-1]);
                    out_next.big[t] = (DEN_W+QUO_W)'(num[t]) >= {out_next.den, QUO_W'(0)};
                    out_next.rem[t] = DEN_W'(num[t] >> QUO_W);
                    out_next.nlo[t] = num[t][QUO_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mid_valid_reg <= in_valid;
            end
            if (mid_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mid_reg <= mid_next;
        end
        if (mid_ready && mid_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

>>> design/qalu_divsqrt.sv
// Pipelined restoring divider (four lanes) and integer square root, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module qalu_divsqrt import qalu_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire ds_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output ds_t       out_data
);

    logic [PIPE_STEPS-1:0] valid_reg;
    ds_t                   stage_reg [PIPE_STEPS];
    ds_t                   step_next [PIPE_STEPS];
    ds_t                   src [PIPE_STEPS];
    logic [PIPE_STEPS-1:0] src_valid;
    logic [PIPE_STEPS:0]   rdy;

    assign rdy[PIPE_STEPS] = out_ready;
    assign in_ready        = rdy[0];
    assign out_valid       = valid_reg[PIPE_STEPS-1];
    assign out_data        = stage_reg[PIPE_STEPS-1];

    for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
        localparam int NB = (k < DIV_STEPS) ? DIV_STEPS - 1 - k : 0;

        logic [SQ_REM_W-1:0] sq_t;
        logic [SQ_REM_W-1:0] sq_trial;
        logic [DEN_W:0]      dv_t [4];

        if (k == 0) begin : g_src_in
            assign src[k]       = in_data;
            assign src_valid[k] = in_valid;
        end else begin : g_src_prev
            assign src[k]       = stage_reg[k-1];
            assign src_valid[k] = valid_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb begin
            step_next[k] = src[k];
            // one root bit from the next pair of radicand bits
            sq_t     = {src[k].srem[SQ_REM_W-3:0], src[k].rad[SQ_IN_W-1-2*k -: 2]};
            sq_trial = SQ_REM_W'({src[k].root, 2'b01});
            if (sq_t >= sq_trial) begin
                step_next[k].srem = sq_t - sq_trial;
                step_next[k].root = {src[k].root[ROOT_W-2:0], 1'b1};
            end else begin
                step_next[k].srem = sq_t;
                step_next[k].root = {src[k].root[ROOT_W-2:0], 1'b0};
            end
            // one quotient bit per lane, in the first DIV_STEPS stages only
            for (int l = 0; l < 4; l++) begin
                dv_t[l] = {src[k].rem[l], src[k].nlo[l][NB]};
                if (k < DIV_STEPS) begin
                    if (dv_t[l] >= {1'b0, src[k].den}) begin
                        step_next[k].rem[l] = DEN_W'(dv_t[l] - {1'b0, src[k].den});
                        step_next[k].quo[l] = {src[k].quo[l][QUO_W-2:0], 1'b1};
                    end else begin
                        step_next[k].rem[l] = dv_t[l][DEN_W-1:0];
                        step_next[k].quo[l] = {src[k].quo[l][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && src_valid[k]) begin
                stage_reg[k] <= step_next[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/qalu_final.sv
// Output stage: sign and saturation of quotient and root, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qalu_final import qalu_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire ds_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    lane_ov [4];

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb begin
        res_next = in_data.direct;
        for (int l = 0; l < 4; l++) begin
            lane_ov[l] = 1'b0;
        end
        unique case (in_data.kind)
            K_DIV: begin
                for (int l = 0; l < 4; l++) begin
                    lane_ov[l] = in_data.big[l]
                        || (!in_data.neg[l] && in_data.quo[l][QUO_W-1])
                        || (in_data.neg[l] && in_data.quo[l][QUO_W-1]
                            && (|in_data.quo[l][QUO_W-2:0]));
                    if (lane_ov[l]) begin
                        res_next.res[l] = in_data.neg[l] ? WORD_MIN : WORD_MAX;
                    end else begin
                        res_next.res[l] = in_data.neg[l] ? WORD_BITS'(~in_data.quo[l] + 1'b1)
                                                         : WORD_BITS'(in_data.quo[l]);
                    end
                end
                res_next.ov = lane_ov[0] | lane_ov[1] | lane_ov[2] | lane_ov[3];
            end
            K_SQRT: begin
                res_next.res = '0;
                res_next.ov  = |in_data.root[ROOT_W-1:WORD_BITS-1];
                res_next.res[0] = res_next.ov ? WORD_MAX : WORD_BITS'(in_data.root);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= res_next;
        end
    end

    `ASSERT_ALWAYS(a_dz_no_ov, aclk, aresetn, !(out_valid_reg && res_reg.dz && res_reg.ov), "divide error with overflow")
    `ASSERT_IMPLIES(a_dz_zero, aclk, aresetn, out_valid_reg && res_reg.dz, res_reg.res == '0, "divide error with nonzero result")
    `ASSERT_IMPLIES(a_eq_zero, aclk, aresetn, out_valid_reg && res_reg.eq, res_reg.res == '0, "equal test with nonzero result")
    `ASSERT_NEXT(a_load, aclk, aresetn, in_valid && in_ready, out_valid_reg, "accepted beat not registered")

endmodule

`default_nettype wire

>>> design/quaternion_alu_unit.sv
// Top level of the pipelined quaternion arithmetic unit.
// Usage:
//   Input beats arrive on s_axis: tuser carries the operation code, tdata the
//   two quaternions a and b in signed Q16.16. Each beat yields exactly one
//   result beat on m_axis: tdata holds the result quaternion, tuser the
//   equal, divide-error and overflow flags.
//   From input accept to m_axis_tvalid a beat passes through one product
//   stage, two summing stages, 33 divider/root stages (one root bit per
//   stage, one quotient bit per lane in all but the last) and one output
//   register. All operations run through the full depth, so results leave
//   in input order. Throughput is one beat per cycle while m_axis accepts;
//   the bit-per-stage divider and root chain sets the depth, not the rate.
//   Every stage holds its own valid bit and advances when the stage after it
//   is empty or advancing, so a stalled m_axis fills bubbles first and
//   s_axis_tready drops only when every stage holds a beat. Nothing is
//   dropped or repeated under stall.
//   Reset (aresetn low, synchronous) empties all stages; data registers are
//   not cleared.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_alu_unit import qalu_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [8*WORD_BITS-1:0]   s_axis_tdata,  // a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k
    input  wire logic [3:0]               s_axis_tuser,  // operation
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [4*WORD_BITS-1:0]        m_axis_tdata,  // res_r, res_i, res_j, res_k
    output logic [2:0]                    m_axis_tuser   // equal_flag, divide_error, overflow
);

    in_item_t in_item;
    logic     mult_valid;
    logic     mult_ready;
    prod_t    mult_data;
    logic     comb_valid;
    logic     comb_ready;
    ds_t      comb_data;
    logic     ds_valid;
    logic     ds_ready;
    ds_t      ds_data;
    result_t  result;

    // unpack the input beat; lane 0 is the real part
    always_comb begin
        in_item.op = op_t'(s_axis_tuser);
        for (int t = 0; t < 4; t++) begin
            in_item.a[t] = s_axis_tdata[t*WORD_BITS +: WORD_BITS];
            in_item.b[t] = s_axis_tdata[(t+4)*WORD_BITS +: WORD_BITS];
        end
    end

    qalu_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .out_data  (mult_data)
    );

    qalu_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .in_data   (mult_data),
        .out_valid (comb_valid),
        .out_ready (comb_ready),
        .out_data  (comb_data)
    );

    qalu_divsqrt u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (comb_valid),
        .in_ready  (comb_ready),
        .in_data   (comb_data),
        .out_valid (ds_valid),
        .out_ready (ds_ready),
        .out_data  (ds_data)
    );

    qalu_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ds_valid),
        .in_ready  (ds_ready),
        .in_data   (ds_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // pack the result beat
    assign m_axis_tdata = {result.res[3], result.res[2], result.res[1], result.res[0]};
    assign m_axis_tuser = {result.ov, result.dz, result.eq};

endmodule

`default_nettype wire
